/* hw/rtl/mtds_pkg.sv */
// ---------------------------------------------------------------------------
// mtds_pkg
// Shared types and codes for the multi-channel touch debounce and swipe block.
// ---------------------------------------------------------------------------
`default_nettype none

package mtds_pkg;

    // Event kinds carried on the result channel
    localparam logic [1:0] KIND_TOUCH     = 2'd0;
    localparam logic [1:0] KIND_RELEASE   = 2'd1;
    localparam logic [1:0] KIND_SWIPE_POS = 2'd2;
    localparam logic [1:0] KIND_SWIPE_NEG = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_TOUCH_THRESHOLD = 2'd0;
    localparam logic [1:0] CFG_ACTIVE_CHANNELS = 2'd1;
    localparam logic [1:0] CFG_SWIPE_MAX_GAP   = 2'd2;
    localparam logic [1:0] CFG_RESTART_GAP     = 2'd3;

    // Reset values of the configuration registers
    localparam logic [15:0] RST_TOUCH_THRESHOLD = 16'd100;
    localparam logic [4:0]  RST_ACTIVE_CHANNELS = 5'd16;
    localparam logic [15:0] RST_SWIPE_MAX_GAP   = 16'd500;
    localparam logic [15:0] RST_RESTART_GAP     = 16'd500;

    // Flags from the shared time-difference unit
    typedef struct packed {
        logic too_far;   // magnitude (or plain age) above the limit
        logic is_neg;    // difference negative as signed 32 bits
        logic is_pos;    // difference positive and nonzero
    } t_gap_res;

endpackage : mtds_pkg

`default_nettype wire

/* hw/rtl/mtds_gap_unit.sv */
// ---------------------------------------------------------------------------
// mtds_gap_unit
// Shared time-difference unit: subtract two 32-bit times modulo 2^32,
// optionally take the signed magnitude, and compare against a 16-bit limit.
// ---------------------------------------------------------------------------
`default_nettype none

module mtds_gap_unit (
    input  wire logic [31:0]       i_a,
    input  wire logic [31:0]       i_b,
    input  wire logic              i_use_abs,
    input  wire logic [15:0]       i_limit,
    output mtds_pkg::t_gap_res     o_res
);

    logic [31:0] w_diff;
    logic [31:0] w_mag;

    // a - b wraps; magnitude of the most negative value stays 2^31
    assign w_diff = i_a - i_b;
    assign w_mag  = (i_use_abs && w_diff[31]) ? (32'd0 - w_diff) : w_diff;

    assign o_res.too_far = (w_mag > {16'd0, i_limit});
    assign o_res.is_neg  = w_diff[31];
    assign o_res.is_pos  = !w_diff[31] && (w_diff != 32'd0);

endmodule : mtds_gap_unit

`default_nettype wire

/* hw/rtl/multi_touch_debounce_swipe.sv */
// ---------------------------------------------------------------------------
// multi_touch_debounce_swipe
// Per-channel touch debouncer with touch/release events and swipe detection
// over the gesture start times of all active channels.
// ---------------------------------------------------------------------------
//  Channel   Handshake                     Beat contents
//  ------    ---------------------------   --------------------------------------
//  input     i_in_valid / o_in_ready       i_channel_index, i_reading, i_now_ms
//  result    o_out_valid / i_out_ready     o_event_kind, o_event_channel,
//                                          o_last_of_run
//  config    i_cfg_we (no wait)            i_cfg_idx, i_cfg_wdata
//
//  An ignored reading or one with no change ends in its accept cycle; a release
//  then loads its beat. A touch: accept, an age check, then a walk over the n
//  active channels (one start-time read and one shared subtract/compare per
//  cycle), then one or two loads; the walk is cut short when a gap fails, and
//  skipped when under three channels are active. Input is not ready until the
//  item is done; a load waits while the last beat is held. Sync reset.
// ---------------------------------------------------------------------------
`default_nettype none

module multi_touch_debounce_swipe #(
    parameter int MAX_CHANNELS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [15:0] i_cfg_wdata,
    // readings
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [3:0]  i_channel_index,
    input  wire logic [15:0] i_reading,
    input  wire logic [31:0] i_now_ms,
    // events
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [1:0]       o_event_kind,
    output logic [3:0]       o_event_channel,
    output logic             o_last_of_run
);

    // widths: address, channel count, count compare
    localparam int LP_IW = $clog2(MAX_CHANNELS);
    localparam int LP_CW = $clog2(MAX_CHANNELS + 1);
    localparam int LP_NW = (LP_CW > 5) ? LP_CW : 5;

    localparam logic [LP_NW-1:0]   LP_MAX_N  = LP_NW'(MAX_CHANNELS);
    localparam logic [LP_NW-1:0]   LP_MIN_SW = LP_NW'(3);
    localparam logic signed [LP_NW:0] LP_NET_POS = (LP_NW+1)'(2);
    localparam logic signed [LP_NW:0] LP_NET_NEG = -((LP_NW+1)'(2));

    // sequencer states
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_AGE    = 3'd1;
    localparam logic [2:0] ST_SCAN   = 3'd2;
    localparam logic [2:0] ST_EMIT_T = 3'd3;
    localparam logic [2:0] ST_EMIT_S = 3'd4;
    localparam logic [2:0] ST_EMIT_R = 3'd5;

    // configuration registers
    logic [15:0] r_threshold;
    logic [4:0]  r_active;
    logic [15:0] r_swipe_gap;
    logic [15:0] r_restart_gap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold   <= mtds_pkg::RST_TOUCH_THRESHOLD;
            r_active      <= mtds_pkg::RST_ACTIVE_CHANNELS;
            r_swipe_gap   <= mtds_pkg::RST_SWIPE_MAX_GAP;
            r_restart_gap <= mtds_pkg::RST_RESTART_GAP;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mtds_pkg::CFG_TOUCH_THRESHOLD: r_threshold   <= i_cfg_wdata;
                mtds_pkg::CFG_ACTIVE_CHANNELS: r_active      <= i_cfg_wdata[4:0];
                mtds_pkg::CFG_SWIPE_MAX_GAP:   r_swipe_gap   <= i_cfg_wdata;
                mtds_pkg::CFG_RESTART_GAP:     r_restart_gap <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // effective channel count, clamped to the build size
    logic [LP_NW-1:0] w_active_ext;
    logic [LP_NW-1:0] w_n;
    assign w_active_ext = LP_NW'(r_active);
    assign w_n          = (w_active_ext > LP_MAX_N) ? LP_MAX_N : w_active_ext;

    // control and datapath registers
    logic [2:0]              r_state, n_state;
    logic [3:0]              r_ch;
    logic [LP_IW-1:0]        r_ch_addr;
    logic [31:0]             r_now;
    logic [1:0]              r_press [MAX_CHANNELS];
    logic [MAX_CHANNELS-1:0] r_vld;
    logic [LP_NW-1:0]        r_idx;
    logic                    r_pend, r_pfirst, r_plast;
    logic [31:0]             r_prev;
    logic signed [LP_NW:0]   r_net;
    logic                    r_tlast;
    logic [1:0]              r_skind;
    logic                    r_ovld;
    logic [1:0]              r_okind;
    logic [3:0]              r_ochan;
    logic                    r_olast;

    // start-time memory with registered read
    logic [31:0]             r_start_mem [MAX_CHANNELS];
    logic [31:0]             r_rd_data;
    logic                    r_rd_vld;
    logic [31:0]             w_rd;

    // incoming channel decode
    logic [LP_NW-1:0] w_ch_ext;
    logic [LP_IW-1:0] w_ch_addr;
    logic             w_accept;
    logic             w_in_range;
    assign w_ch_ext   = LP_NW'(i_channel_index);
    assign w_ch_addr  = w_ch_ext[LP_IW-1:0];
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_in_range = (w_ch_ext < w_n);

    // debounce counter step
    logic [1:0] w_cnt, w_cnt_new;
    logic       w_was, w_is;
    always_comb begin
        w_cnt = r_press[w_ch_addr];
        if (i_reading > r_threshold) begin
            w_cnt_new = (w_cnt < 2'd2) ? (w_cnt + 2'd1) : 2'd2;
        end else begin
            w_cnt_new = (w_cnt > 2'd0) ? (w_cnt - 2'd1) : 2'd0;
        end
        w_was = (w_cnt != 2'd0);
        w_is  = (w_cnt_new != 2'd0);
    end

    // shared difference unit: age check in AGE, neighbor gaps in SCAN
    mtds_pkg::t_gap_res w_gap;
    logic               w_age_st;
    assign w_age_st = (r_state == ST_AGE);

    mtds_gap_unit u_gap (
        .i_a       (w_age_st ? r_now : w_rd),
        .i_b       (w_age_st ? w_rd : r_prev),
        .i_use_abs (!w_age_st),
        .i_limit   (w_age_st ? r_restart_gap : r_swipe_gap),
        .o_res     (w_gap)
    );

    assign w_rd = r_rd_vld ? r_rd_data : 32'd0;

    // walk bookkeeping
    logic                  w_issue;
    logic                  w_step;      // a neighbor pair is evaluated this cycle
    logic signed [LP_NW:0] w_net_next;
    logic [LP_IW-1:0]      w_rd_addr;
    logic                  w_can_push;
    logic                  w_mem_we;

    assign w_issue   = (r_state == ST_SCAN) && (r_idx < w_n);
    assign w_step    = (r_state == ST_SCAN) && r_pend && !r_pfirst;
    assign w_rd_addr = (r_state == ST_IDLE) ? w_ch_addr : r_idx[LP_IW-1:0];
    assign w_can_push = !r_ovld || i_out_ready;
    assign w_mem_we  = w_age_st && w_gap.too_far;

    always_comb begin
        w_net_next = r_net;
        if (w_gap.is_neg) begin
            w_net_next = r_net - (LP_NW+1)'(1);
        end else if (w_gap.is_pos) begin
            w_net_next = r_net + (LP_NW+1)'(1);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept && w_in_range && (w_is != w_was)) begin
                    n_state = w_is ? ST_AGE : ST_EMIT_R;
                end
            end
            ST_AGE: begin
                n_state = (w_n < LP_MIN_SW) ? ST_EMIT_T : ST_SCAN;
            end
            ST_SCAN: begin
                if (w_step && (w_gap.too_far || r_plast)) begin
                    n_state = ST_EMIT_T;
                end
            end
            ST_EMIT_T: begin
                if (w_can_push) begin
                    n_state = r_tlast ? ST_IDLE : ST_EMIT_S;
                end
            end
            ST_EMIT_S, ST_EMIT_R: begin
                if (w_can_push) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_in_ready = (r_state == ST_IDLE);

    // memory port
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_start_mem[r_ch_addr] <= r_now;
        end
        r_rd_data <= r_start_mem[w_rd_addr];
        r_rd_vld  <= r_vld[w_rd_addr];
    end

    // item capture and walk datapath
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ch      <= i_channel_index;
            r_ch_addr <= w_ch_addr;
            r_now     <= i_now_ms;
        end
        if (w_age_st) begin
            r_idx   <= '0;
            r_net   <= '0;
            r_tlast <= 1'b1;
        end else if (r_state == ST_SCAN) begin
            if (w_issue) begin
                r_idx <= r_idx + LP_NW'(1);
            end
            if (r_pend && r_pfirst) begin
                r_prev <= w_rd;
            end
            if (w_step) begin
                r_prev <= w_rd;
                r_net  <= w_net_next;
                if (!w_gap.too_far && r_plast) begin
                    if (w_net_next >= LP_NET_POS) begin
                        r_tlast <= 1'b0;
                        r_skind <= mtds_pkg::KIND_SWIPE_POS;
                    end else if (w_net_next <= LP_NET_NEG) begin
                        r_tlast <= 1'b0;
                        r_skind <= mtds_pkg::KIND_SWIPE_NEG;
                    end
                end
            end
        end
    end

    // control state: sequencer, read pipeline flags, counters, valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_pend   <= 1'b0;
            r_pfirst <= 1'b0;
            r_plast  <= 1'b0;
            r_vld    <= '0;
            for (int i = 0; i < MAX_CHANNELS; i++) begin
                r_press[i] <= 2'd0;
            end
        end else begin
            r_state  <= n_state;
            r_pend   <= w_issue;
            r_pfirst <= (r_idx == '0);
            r_plast  <= (r_idx == (w_n - LP_NW'(1)));
            if (w_accept && w_in_range) begin
                r_press[w_ch_addr] <= w_cnt_new;
            end
            if (w_mem_we) begin
                r_vld[r_ch_addr] <= 1'b1;
            end
            // a completed walk clears every active start time
            if (w_step && !w_gap.too_far && r_plast) begin
                for (int i = 0; i < MAX_CHANNELS; i++) begin
                    if (LP_NW'(i) < w_n) begin
                        r_vld[i] <= 1'b0;
                    end
                end
            end
        end
    end

    // result register
    logic       w_push;
    logic [1:0] w_push_kind;
    logic [3:0] w_push_chan;
    logic       w_push_last;
    always_comb begin
        w_push      = w_can_push &&
                      ((r_state == ST_EMIT_T) || (r_state == ST_EMIT_S) ||
                       (r_state == ST_EMIT_R));
        w_push_kind = mtds_pkg::KIND_TOUCH;
        w_push_chan = r_ch;
        w_push_last = 1'b1;
        case (r_state)
            ST_EMIT_T: w_push_last = r_tlast;
            ST_EMIT_S: begin
                w_push_kind = r_skind;
                w_push_chan = 4'd0;
            end
            ST_EMIT_R: w_push_kind = mtds_pkg::KIND_RELEASE;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (w_push) begin
            r_ovld <= 1'b1;
        end else if (i_out_ready) begin
            r_ovld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_okind <= w_push_kind;
            r_ochan <= w_push_chan;
            r_olast <= w_push_last;
        end
    end

    assign o_out_valid     = r_ovld;
    assign o_event_kind    = r_okind;
    assign o_event_channel = r_ochan;
    assign o_last_of_run   = r_olast;

endmodule : multi_touch_debounce_swipe

`default_nettype wire
